// File: hw/rtl/nvs_pkg.sv
package nvs_pkg;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_DIV_Y, SQ_DIV_X, SQ_MUL, SQ_ADD,
    SQ_RD_Y, SQ_RD_U, SQ_RD_V, SQ_CONV, SQ_FIN
  } nvs_seq_e;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CONV = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SMALL = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_DST_W = 2'd2;
  localparam logic [1:0] REG_DST_H = 2'd3;

  localparam int RdAddrW = 19;

  typedef logic signed [9:0] ctab_t [256];
  typedef logic [5:0] qtab_t [256];

  typedef struct packed {
    logic               en;
    logic [RdAddrW-1:0] addr;
  } nvs_rd_t;

  typedef struct packed {
    logic [15:0] pix;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } nvs_pix_t;

  function automatic ctab_t build_rv();
    ctab_t t;
    int d, m, q;
    for (int i = 0; i < 256; i++) begin
      d = i - 128;
      m = (d < 0) ? -d : d;
      q = m * 1402 / 1000;
      t[i] = 10'((d < 0) ? -q : q);
    end
    return t;
  endfunction

  function automatic ctab_t build_gv();
    ctab_t t;
    int d, m, q;
    for (int i = 0; i < 256; i++) begin
      d = i - 128;
      m = (d < 0) ? -d : d;
      q = m * 71414 / 100000;
      t[i] = 10'((d < 0) ? -q : q);
    end
    return t;
  endfunction

  function automatic ctab_t build_gu();
    ctab_t t;
    int d, m, q;
    for (int i = 0; i < 256; i++) begin
      d = i - 128;
      m = (d < 0) ? -d : d;
      q = m * 34413 / 100000;
      t[i] = 10'((d < 0) ? -q : q);
    end
    return t;
  endfunction

  function automatic ctab_t build_bu();
    ctab_t t;
    int d, m, q;
    for (int i = 0; i < 256; i++) begin
      d = i - 128;
      m = (d < 0) ? -d : d;
      q = m * 1772 / 1000;
      t[i] = 10'((d < 0) ? -q : q);
    end
    return t;
  endfunction

  function automatic qtab_t build_q5();
    qtab_t t;
    for (int i = 0; i < 256; i++) t[i] = 6'(i * 31 / 255);
    return t;
  endfunction

  function automatic qtab_t build_q6();
    qtab_t t;
    for (int i = 0; i < 256; i++) t[i] = 6'(i * 63 / 255);
    return t;
  endfunction

  localparam ctab_t RV_TAB = build_rv();
  localparam ctab_t GV_TAB = build_gv();
  localparam ctab_t GU_TAB = build_gu();
  localparam ctab_t BU_TAB = build_bu();
  localparam qtab_t Q5_TAB = build_q5();
  localparam qtab_t Q6_TAB = build_q6();

  function automatic logic [7:0] clamp8(logic signed [10:0] v);
    logic [7:0] res;
    if (v < 0) res = 8'd0;
    else if (v > 11'sd255) res = 8'd255;
    else res = v[7:0];
    return res;
  endfunction

endpackage

// File: hw/rtl/nvs_div.sv
module nvs_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [17:0] num_i,
  input  logic [8:0]  den_i,
  output logic        done_o,
  output logic [8:0]  quo_o
);
  logic       busy_q, busy_d;
  logic [3:0] cnt_q, cnt_d;
  logic [8:0] rem_q, rem_d, sh_q, sh_d, den_q, den_d;
  logic [9:0] trial;
  logic       ge;

  assign trial = {rem_q, sh_q[8]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 4'd9;
      rem_d  = num_i[17:9];
      sh_d   = num_i[8:0];
      den_d  = den_i;
    end else if (busy_q && cnt_q != 4'd0) begin
      rem_d = ge ? 9'(trial - {1'b0, den_q}) : trial[8:0];
      sh_d  = {sh_q[7:0], ge};
      cnt_d = cnt_q - 4'd1;
    end else if (busy_q) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && cnt_q == 4'd0;
  assign quo_o  = sh_q;
endmodule

// File: hw/rtl/nvs_store.sv
module nvs_store #(
  parameter int Depth = 115200
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [16:0]           waddr_i,
  input  logic [7:0]            wdata_i,
  input  nvs_pkg::nvs_rd_t      rd_i,
  output logic [7:0]            rdata_o
);
  import nvs_pkg::*;
  localparam int AW = $clog2(Depth);

  logic [7:0]    mem [Depth];
  logic [31:0]   wa32, ra32;
  logic [7:0]    rd_q;
  logic          hit_q;

  assign wa32 = 32'(waddr_i);
  assign ra32 = 32'(rd_i.addr);

  always_ff @(posedge clk_i) begin
    if (we_i && wa32 < 32'(Depth)) mem[wa32[AW-1:0]] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      hit_q <= ra32 < 32'(Depth);
      rd_q  <= mem[ra32[AW-1:0]];
    end
  end

  assign rdata_o = hit_q ? rd_q : 8'd0;
endmodule

// File: hw/rtl/nvs_conv.sv
module nvs_conv (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [7:0]        y_i,
  input  logic [7:0]        u_i,
  input  logic [7:0]        v_i,
  output nvs_pkg::nvs_pix_t pix_o
);
  import nvs_pkg::*;
  logic signed [10:0] ys, rs, gs, bs;
  logic [7:0] r, g, b;
  nvs_pix_t pix_q;

  always_comb begin
    ys = signed'({3'b000, y_i});
    rs = ys + 11'(RV_TAB[v_i]);
    gs = ys - 11'(GU_TAB[u_i]) - 11'(GV_TAB[v_i]);
    bs = ys + 11'(BU_TAB[u_i]);
    r  = clamp8(rs);
    g  = clamp8(gs);
    b  = clamp8(bs);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q.pix   <= {Q5_TAB[r][4:0], Q6_TAB[g], Q5_TAB[b][4:0]};
      pix_q.red   <= r;
      pix_q.green <= g;
      pix_q.blue  <= b;
    end
  end

  assign pix_o = pix_q;
endmodule

// File: hw/rtl/nv12_scaled_to_rgb.sv
// channel   | dir | handshake                     | payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready   | tuser operation; tdata address, byte, row, col
// m_axis    | out | m_axis_tvalid/m_axis_tready   | tdata pixel_565, red, green, blue, status
// cfg       | in  | cfg_valid_i/cfg_ready_o       | cfg_index_i register, cfg_data_i value
// A load item writes the frame store at acceptance.
// A convert item runs two 9-step divisions on one shared divider, address
// products and sums, and three reads on the single store read port.
// A failed size or range check skips to the finish state. Reset returns the registers to
// 320, 240, 320, 240; the store contents are not cleared.
// A stalled result holds in the output register; the next convert waits in the finish state until it is taken.
module nv12_scaled_to_rgb #(
  parameter int MAX_WIDTH  = 320,
  parameter int MAX_HEIGHT = 240
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // load_address, load_byte, out_row, out_col, zero pad
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // pixel_565, red, green, blue, status, zero pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);
  import nvs_pkg::*;
  localparam int Depth = MAX_WIDTH * MAX_HEIGHT * 3 / 2;

  nvs_seq_e   seq_q, seq_d;
  logic [8:0] src_w_q, dst_w_q;
  logic [7:0] src_h_q, dst_h_q;
  logic [8:0] col_q, col_d, sx_q, sx_d;
  logic [8:0] sy_q, sy_d;
  logic [1:0] stat_q, stat_d;
  logic [17:0] ymul_q;
  logic [16:0] uvm_q, base_q;
  logic [RdAddrW-1:0] ya_q, uva_q;
  logic [7:0] y_q, u_q;
  logic        mv_q, mv_d;
  logic [47:0] md_q, md_d;

  logic        acc;
  logic [16:0] in_addr;
  logic [7:0]  in_byte, in_row;
  logic [8:0]  in_col;
  logic        div_start, div_done;
  logic [17:0] div_num;
  logic [8:0]  div_den, quo;
  nvs_rd_t     rd;
  logic [7:0]  rdata;
  logic        conv_en;
  nvs_pix_t    pix;

  assign in_addr = s_axis_tdata[16:0];
  assign in_byte = s_axis_tdata[24:17];
  assign in_row  = s_axis_tdata[32:25];
  assign in_col  = s_axis_tdata[41:33];

  assign s_axis_tready = seq_q == SQ_IDLE;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= 9'd320;
      src_h_q <= 8'd240;
      dst_w_q <= 9'd320;
      dst_h_q <= 8'd240;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SRC_W: src_w_q <= cfg_data_i;
        REG_SRC_H: src_h_q <= cfg_data_i[7:0];
        REG_DST_W: dst_w_q <= cfg_data_i;
        REG_DST_H: dst_h_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    seq_d     = seq_q;
    col_d     = col_q;
    sy_d      = sy_q;
    sx_d      = sx_q;
    stat_d    = stat_q;
    mv_d      = mv_q && !m_axis_tready;
    md_d      = md_q;
    div_start = 1'b0;
    div_num   = 18'(in_row * src_h_q);
    div_den   = {1'b0, dst_h_q};
    rd.en     = 1'b0;
    rd.addr   = ya_q;
    conv_en   = 1'b0;
    unique case (seq_q)
      SQ_IDLE: begin
        if (acc && s_axis_tuser == OP_CONV) begin
          col_d = in_col;
          if (src_w_q < dst_w_q || src_h_q < dst_h_q) begin
            stat_d = STAT_SMALL;
            seq_d  = SQ_FIN;
          end else if (in_row >= dst_h_q || in_col >= dst_w_q) begin
            stat_d = STAT_RANGE;
            seq_d  = SQ_FIN;
          end else begin
            stat_d    = STAT_OK;
            div_start = 1'b1;
            seq_d     = SQ_DIV_Y;
          end
        end
      end
      SQ_DIV_Y: begin
        div_num = 18'(col_q * src_w_q);
        div_den = dst_w_q;
        if (div_done) begin
          sy_d      = quo;
          div_start = 1'b1;
          seq_d     = SQ_DIV_X;
        end
      end
      SQ_DIV_X: begin
        if (div_done) begin
          sx_d  = quo;
          seq_d = SQ_MUL;
        end
      end
      SQ_MUL: seq_d = SQ_ADD;
      SQ_ADD: seq_d = SQ_RD_Y;
      SQ_RD_Y: begin
        rd.en = 1'b1;
        seq_d = SQ_RD_U;
      end
      SQ_RD_U: begin
        rd.en   = 1'b1;
        rd.addr = uva_q;
        seq_d   = SQ_RD_V;
      end
      SQ_RD_V: begin
        rd.en   = 1'b1;
        rd.addr = RdAddrW'(uva_q + 1'b1);
        seq_d   = SQ_CONV;
      end
      SQ_CONV: begin
        conv_en = 1'b1;
        seq_d   = SQ_FIN;
      end
      SQ_FIN: begin
        if (!mv_q || m_axis_tready) begin
          mv_d = 1'b1;
          if (stat_q == STAT_OK)
            md_d = {6'd0, STAT_OK, pix.blue, pix.green, pix.red, pix.pix};
          else
            md_d = {6'd0, stat_q, 40'd0};
          seq_d = SQ_IDLE;
        end
      end
      default: seq_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SQ_IDLE;
      mv_q  <= 1'b0;
    end else begin
      seq_q <= seq_d;
      mv_q  <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    sy_q   <= sy_d;
    sx_q   <= sx_d;
    stat_q <= stat_d;
    md_q   <= md_d;
    if (seq_q == SQ_MUL) begin
      ymul_q <= 18'(sy_q * src_w_q);
      uvm_q  <= 17'(sy_q[8:1] * src_w_q);
      base_q <= 17'(src_w_q * src_h_q);
    end
    if (seq_q == SQ_ADD) begin
      ya_q  <= RdAddrW'(ymul_q) + RdAddrW'(sx_q);
      uva_q <= RdAddrW'(base_q) + RdAddrW'(uvm_q) + RdAddrW'({sx_q[8:1], 1'b0});
    end
    if (seq_q == SQ_RD_U) y_q <= rdata;
    if (seq_q == SQ_RD_V) u_q <= rdata;
  end

  nvs_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(quo)
  );

  nvs_store #(.Depth(Depth)) u_store (
    .clk_i,
    .we_i(acc && s_axis_tuser == OP_LOAD),
    .waddr_i(in_addr), .wdata_i(in_byte),
    .rd_i(rd), .rdata_o(rdata)
  );

  nvs_conv u_conv (
    .clk_i, .en_i(conv_en),
    .y_i(y_q), .u_i(u_q), .v_i(rdata),
    .pix_o(pix)
  );

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;
endmodule

// File: hw/rtl/nvs_checker.sv
module nvs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [1:0]  cfg_index_i,
  input logic [8:0]  cfg_data_i
);
  import nvs_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled item changed");

  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[41:40] != 2'd3)
    else $error("bad status code");

  a_errz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[41:40] != STAT_OK |-> m_axis_tdata[39:0] == 40'd0)
    else $error("error item carries pixel data");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_LOAD |=> s_axis_tready)
    else $error("load item stalled input");
endmodule

bind nv12_scaled_to_rgb nvs_checker u_nvs_checker (.*);
